@@ rtl/core/lim_pkg.sv @@
`default_nettype none

package lim_pkg;

   localparam int unsigned CNT_W         = 16;
   localparam int unsigned DELAY_W       = 16;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned REQ_TDATA_W   = 8;
   localparam int unsigned RSP_TDATA_W   = 8;

   localparam logic [CNT_W-1:0] CHECK_SETTLE_TICKS = 16'd10;
   localparam logic [CNT_W-1:0] CNT_MAX            = {CNT_W{1'b1}};
   localparam logic [DELAY_W-1:0] DELAY_RESET      = 16'd20;

   localparam logic [CSR_INDEX_W-1:0] CSR_UP_START_DELAY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_START_DELAY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DELAY       = 2'd2;

   typedef enum logic [3:0] {
      MODE_INIT     = 4'd0,
      MODE_CHECK    = 4'd1,
      MODE_UP_START = 4'd2,
      MODE_UP_RUN   = 4'd3,
      MODE_UP_STOP  = 4'd4,
      MODE_DN_START = 4'd5,
      MODE_DN_RUN   = 4'd6,
      MODE_DN_STOP  = 4'd7,
      MODE_EXITED   = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_NONE = 2'd0,
      PHASE_UP   = 2'd1,
      PHASE_DOWN = 2'd2
   } phase_type;

   typedef struct packed {
      logic taught;
      logic button_down;
      logic button_up;
      logic down_limit;
      logic up_limit;
      logic door_relay;
   } contacts_type;

   typedef struct packed {
      logic [DELAY_W-1:0] stop_delay;
      logic [DELAY_W-1:0] down_start_delay;
      logic [DELAY_W-1:0] up_start_delay;
   } delays_type;

endpackage

`default_nettype wire

@@ rtl/core/lim_next.sv @@
`default_nettype none

module lim_next (
   input  lim_pkg::mode_type         mode,
   input  logic [lim_pkg::CNT_W-1:0] cnt,
   input  lim_pkg::contacts_type     contacts,
   input  lim_pkg::delays_type       delays,
   output lim_pkg::mode_type         next_mode
);
   import lim_pkg::*;

   logic door;
   logic ul;
   logic dl;
   logic bu;
   logic bd;

   assign door = contacts.door_relay;
   assign ul   = contacts.up_limit;
   assign dl   = contacts.down_limit;
   assign bu   = contacts.button_up;
   assign bd   = contacts.button_down;

   always_comb begin
      next_mode = mode;
      unique case (mode)
         MODE_INIT: begin
            if (contacts.taught) begin
               next_mode = MODE_EXITED;
            end else if (door) begin
               next_mode = MODE_CHECK;
            end
         end
         MODE_CHECK: begin
            if (!door) begin
               next_mode = MODE_INIT;
            end else if (cnt > CHECK_SETTLE_TICKS) begin
               if (!ul && bu && !bd) begin
                  next_mode = MODE_UP_START;
               end else if (!dl && bd && !bu) begin
                  next_mode = MODE_DN_START;
               end
            end
         end
         MODE_UP_START: begin
            if (!bu || ul) begin
               next_mode = MODE_CHECK;
            end else if (cnt > delays.up_start_delay) begin
               next_mode = MODE_UP_RUN;
            end
         end
         MODE_UP_RUN: begin
            if (!bu || ul) begin
               next_mode = MODE_UP_STOP;
            end
         end
         MODE_DN_START: begin
            if (!bd || dl) begin
               next_mode = MODE_CHECK;
            end else if (cnt > delays.down_start_delay) begin
               next_mode = MODE_DN_RUN;
            end
         end
         MODE_DN_RUN: begin
            if (!bd || dl) begin
               next_mode = MODE_DN_STOP;
            end
         end
         MODE_UP_STOP, MODE_DN_STOP: begin
            if (cnt > delays.stop_delay) begin
               next_mode = MODE_CHECK;
            end
         end
         default: begin
            next_mode = mode;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/lift_inspection_mode_fsm.sv @@
// Channel  Direction  Width  Contents
// req      in         8      door_relay, up_limit, down_limit, button_up, button_down, taught
// rsp      out        8      mode_state[3:0], travel_phase[5:4], to_automatic[6]
// csr      in         2+16   register index, delay value
//
// One request per cycle; each request gives one response in the following cycle.
// Mode and tick count update at request acceptance; the response register
// holds the result until taken, and a new request is taken in the same cycle.
// A stalled response stalls requests. Reset clears mode, count and delays to
// their initial values; csr writes are always taken.
`default_nettype none

module lift_inspection_mode_fsm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] door_relay [1] up_limit [2] down_limit [3] button_up [4] button_down
   // [5] taught [7:6] zero
   input  logic [lim_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] mode_state [5:4] travel_phase [6] to_automatic [7] zero
   output logic [lim_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lim_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lim_pkg::DELAY_W-1:0]        csr_data
);
   import lim_pkg::*;

   mode_type               mode_ff;
   mode_type               mode_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   delays_type             delays_ff;
   delays_type             delays_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   contacts_type           contacts;
   mode_type               next_mode;
   phase_type              phase;
   logic                   req_fire;

   assign contacts   = contacts_type'(req_tdata[5:0]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   lim_next u_next (
      .mode      (mode_ff),
      .cnt       (cnt_ff),
      .contacts  (contacts),
      .delays    (delays_ff),
      .next_mode (next_mode)
   );

   always_comb begin
      unique case (next_mode)
         MODE_UP_START, MODE_UP_RUN, MODE_UP_STOP: phase = PHASE_UP;
         MODE_DN_START, MODE_DN_RUN, MODE_DN_STOP: phase = PHASE_DOWN;
         default:                                  phase = PHASE_NONE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      delays_in    = delays_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         mode_in = next_mode;
         if (next_mode != mode_ff) begin
            cnt_in = '0;
         end else if (cnt_ff != CNT_MAX) begin
            cnt_in = cnt_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, (next_mode == MODE_EXITED), phase, next_mode};
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_UP_START_DELAY:   delays_in.up_start_delay   = csr_data;
            CSR_DOWN_START_DELAY: delays_in.down_start_delay = csr_data;
            CSR_STOP_DELAY:       delays_in.stop_delay       = csr_data;
            default:              delays_in                  = delays_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         delays_ff    <= '{stop_delay: DELAY_RESET, down_start_delay: DELAY_RESET,
                           up_start_delay: DELAY_RESET};
      end else begin
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         delays_ff    <= delays_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/lim_checker.sv @@
`default_nettype none

module lim_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [lim_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import lim_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_req_makes_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response");

   a_auto_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6] == (rsp_tdata[3:0] == MODE_EXITED))
      else $error("to_automatic disagrees with mode_state");

   a_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:4] == PHASE_UP) ==
         (rsp_tdata[3:0] == MODE_UP_START || rsp_tdata[3:0] == MODE_UP_RUN ||
          rsp_tdata[3:0] == MODE_UP_STOP))
      else $error("travel_phase up disagrees with mode_state");

   a_exit_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[3:0] == MODE_EXITED ##1 rsp_tvalid
      |-> rsp_tdata[3:0] == MODE_EXITED)
      else $error("left the exited mode");

endmodule

bind lift_inspection_mode_fsm lim_checker u_lim_checker (.*);

`default_nettype wire
